[sv/assert_macros.svh]
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define RDMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RDMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RDMC_ASSERT(lbl, prop, msg)
`define RDMC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[sv/rdmc_pkg.sv]
`timescale 1ns / 1ps

package rdmc_pkg;

  typedef enum logic [2:0] {
    MODE_FWD   = 3'd0,
    MODE_RIGHT = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_AUTO  = 3'd4,
    MODE_STOP  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    MOT_STOP  = 3'd0,
    MOT_FWD   = 3'd1,
    MOT_BACK  = 3'd2,
    MOT_RIGHT = 3'd3,
    MOT_LEFT  = 3'd4
  } motion_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SPEED = 2'd2;

  localparam logic [15:0] MIN_DISTANCE_RST = 16'd3000;
  localparam logic [9:0]  BATTERY_MIN_RST  = 10'd580;
  localparam logic [7:0]  FOLLOW_SPEED_RST = 8'd95;
  localparam logic [7:0]  SPEED_RST        = 8'd255;
  localparam logic [7:0]  SPEED_FULL       = 8'd255;
  localparam logic [7:0]  SPEED_AUTO_EXIT  = 8'd154;
  localparam logic [7:0]  FOLLOW_FWD_DROP  = 8'd10;

  localparam logic [7:0] CMD_FWD       = 8'h46; // F
  localparam logic [7:0] CMD_BACK      = 8'h42; // B
  localparam logic [7:0] CMD_RIGHT     = 8'h52; // R
  localparam logic [7:0] CMD_LEFT      = 8'h4C; // L
  localparam logic [7:0] CMD_STOP      = 8'h53; // S
  localparam logic [7:0] CMD_AUTO      = 8'h58; // X
  localparam logic [7:0] CMD_AUTO_EXIT = 8'h78; // x
  localparam logic [7:0] CMD_FULL      = 8'h71; // q
  localparam logic [7:0] CMD_DIGIT_LO  = 8'h30; // 0
  localparam logic [7:0] CMD_DIGIT_HI  = 8'h39; // 9

  typedef struct packed {
    logic [15:0] min_distance;
    logic [9:0]  battery_min;
    logic [7:0]  follow_speed;
  } cfg_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [7:0]  cmd_byte;
    logic [15:0] distance;
    logic [9:0]  battery_one;
    logic [9:0]  battery_two;
    logic        line_left;
    logic        line_right;
  } in_item_t;

  typedef struct packed {
    logic [2:0] motion;
    logic [7:0] drive_speed;
    logic [2:0] mode_now;
    logic       echo_valid;
    logic [7:0] echo_byte;
  } out_item_t;

  function automatic logic [7:0] digit_speed(input logic [3:0] digit);
    logic [7:0] spd;
    unique case (digit)
      4'd0:    spd = 8'd0;
      4'd1:    spd = 8'd90;
      4'd2:    spd = 8'd106;
      4'd3:    spd = 8'd122;
      4'd4:    spd = 8'd138;
      4'd5:    spd = 8'd154;
      4'd6:    spd = 8'd170;
      4'd7:    spd = 8'd195;
      4'd8:    spd = 8'd215;
      4'd9:    spd = 8'd235;
      default: spd = 8'd0;
    endcase
    return spd;
  endfunction

endpackage

[sv/rdmc_if.sv]
`timescale 1ns / 1ps

interface rdmc_in_if import rdmc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdmc_out_if import rdmc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/remote_drive_mode_controller.sv]
`timescale 1ns / 1ps
// Remote drive mode controller.
// in_if carries one control-loop pass per transaction: optional command byte,
// obstacle distance, two battery readings and two line-sensor bits.
// out_if returns exactly one transaction per input: motion code, speed,
// current mode and the echoed command byte.
// cfg_we/cfg_index/cfg_wdata write min_distance (0), battery_min (1) and
// follow_speed (2); write only while no transaction is in flight.
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while out_if is ready; the mode
// and speed registers update in the same cycle the result register loads.
// Reset (rst_n low, synchronous): stop mode, speed 255, config registers
// back to 3000 / 580 / 95, both stages empty.
// When out_if stalls, the result register holds and the input register
// keeps one more transaction; in_if.ready drops only when both are full.
`include "assert_macros.svh"

module remote_drive_mode_controller import rdmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rdmc_in_if.sink               in_if,
  rdmc_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  logic      item_valid;
  in_item_t  item;
  out_item_t result;
  logic      load;

  rdmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rdmc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .load       (load),
    .item_valid (item_valid),
    .item       (item)
  );

  rdmc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  rdmc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .load       (load),
    .out_if     (out_if)
  );

  `RDMC_ASSERT_ALWAYS(a_out_empty_after_reset, !rst_n |=> !out_if.valid, "result valid after reset")
  `RDMC_ASSERT(a_stop_zero_speed, (out_if.valid && out_if.data.motion == MOT_STOP) |-> (out_if.data.drive_speed == 8'd0), "stop with nonzero speed")
  `RDMC_ASSERT(a_stop_mode_no_motion, (out_if.valid && out_if.data.mode_now == MODE_STOP) |-> (out_if.data.motion == MOT_STOP), "motion in stop mode")
  `RDMC_ASSERT(a_echo_clear, (out_if.valid && !out_if.data.echo_valid) |-> (out_if.data.echo_byte == 8'd0), "echo byte without command")

endmodule

[sv/rdmc_cfg_regs.sv]
`timescale 1ns / 1ps

module rdmc_cfg_regs import rdmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_DISTANCE: cfg_nxt.min_distance = cfg_wdata;
        CFG_BATTERY_MIN:  cfg_nxt.battery_min  = cfg_wdata[9:0];
        CFG_FOLLOW_SPEED: cfg_nxt.follow_speed = cfg_wdata[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_distance <= MIN_DISTANCE_RST;
      cfg_r.battery_min  <= BATTERY_MIN_RST;
      cfg_r.follow_speed <= FOLLOW_SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/rdmc_in_stage.sv]
`timescale 1ns / 1ps

module rdmc_in_stage import rdmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rdmc_in_if.sink   in_if,
  input  logic      load,
  output logic      item_valid,
  output in_item_t  item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;
  logic     take;

  assign in_if.ready = !valid_r || load;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (load) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_if.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

[sv/rdmc_core.sv]
`timescale 1ns / 1ps

module rdmc_core import rdmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  mode_t      drive_mode_r;
  mode_t      drive_mode_nxt;
  logic [7:0] speed_level_r;
  logic [7:0] speed_level_nxt;

  always_comb begin
    mode_t      mode;
    logic [7:0] spd;
    motion_t    motion;
    logic [7:0] out_spd;
    logic       clear;

    mode    = drive_mode_r;
    spd     = speed_level_r;
    motion  = MOT_STOP;
    out_spd = 8'd0;

    if (item.cmd_valid) begin
      if (drive_mode_r != MODE_AUTO) begin
        unique case (item.cmd_byte)
          CMD_FWD:   mode = MODE_FWD;
          CMD_BACK:  mode = MODE_BACK;
          CMD_RIGHT: mode = MODE_RIGHT;
          CMD_LEFT:  mode = MODE_LEFT;
          CMD_STOP:  mode = MODE_STOP;
          CMD_AUTO: begin
            spd  = cfg.follow_speed;
            mode = MODE_AUTO;
          end
          CMD_FULL:  spd = SPEED_FULL;
          default: begin
            if (item.cmd_byte >= CMD_DIGIT_LO && item.cmd_byte <= CMD_DIGIT_HI) begin
              spd = digit_speed(item.cmd_byte[3:0]);
            end
          end
        endcase
      end else if (item.cmd_byte == CMD_AUTO_EXIT) begin
        spd  = SPEED_AUTO_EXIT;
        mode = MODE_STOP;
      end
    end

    if (item.battery_one <= cfg.battery_min || item.battery_two <= cfg.battery_min) begin
      mode = MODE_STOP;
    end

    clear = item.distance >= cfg.min_distance;

    unique case (mode)
      MODE_FWD: begin
        if (clear) begin
          motion  = MOT_FWD;
          out_spd = spd;
        end
      end
      MODE_RIGHT: begin
        if (clear) begin
          motion  = MOT_RIGHT;
          out_spd = spd;
        end
      end
      MODE_BACK: begin
        motion  = MOT_BACK;
        out_spd = spd;
      end
      MODE_LEFT: begin
        if (clear) begin
          motion  = MOT_LEFT;
          out_spd = spd;
        end
      end
      MODE_AUTO: begin
        if (clear) begin
          priority if (!item.line_right && !item.line_left) begin
            motion  = MOT_FWD;
            out_spd = spd - FOLLOW_FWD_DROP;
          end else if (item.line_right) begin
            motion  = MOT_RIGHT;
            out_spd = spd;
          end else begin
            motion  = MOT_LEFT;
            out_spd = spd;
          end
        end
      end
      default: mode = MODE_STOP;
    endcase

    drive_mode_nxt     = mode;
    speed_level_nxt    = spd;
    result.motion      = motion;
    result.drive_speed = out_spd;
    result.mode_now    = mode;
    result.echo_valid  = item.cmd_valid;
    result.echo_byte   = item.cmd_valid ? item.cmd_byte : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r  <= MODE_STOP;
      speed_level_r <= SPEED_RST;
    end else if (load) begin
      drive_mode_r  <= drive_mode_nxt;
      speed_level_r <= speed_level_nxt;
    end
  end

endmodule

[sv/rdmc_out_stage.sv]
`timescale 1ns / 1ps

module rdmc_out_stage import rdmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  out_item_t  result,
  output logic       load,
  rdmc_out_if.source out_if
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign load = item_valid && (!valid_r || out_if.ready);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_if.valid = valid_r;
  assign out_if.data  = data_r;

endmodule
